[rtl/pcg_pkg.sv]
// Shared types and constants of the PCG32 XSH-RR generator.
`default_nettype none
package pcg_pkg;

  localparam int unsigned StateW = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StreamW = 63;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CfgIdxW = 1;

  // Operation codes of a request
  localparam logic [OpW-1:0] OpReseed  = 2'd0;
  localparam logic [OpW-1:0] OpRaw     = 2'd1;
  localparam logic [OpW-1:0] OpBounded = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSeed   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStream = 1'b1;

  localparam logic [StateW-1:0]  SeedReset   = 64'h0000_0000_00C0_FFEE;
  localparam logic [StreamW-1:0] StreamReset = 63'h1234;

  // LCG multiplier, split into halves for the shared 32x32 multiplier
  localparam logic [StateW-1:0] LcgMult = 64'h5851_F42D_4C95_7F2D;

  typedef struct packed {
    logic              done;
    logic [StateW-1:0] next_state;
    logic [WordW-1:0]  draw;
  } lcg_res_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

[rtl/pcg_lcg.sv]
// LCG step on a shared 32x32 multiplier, plus the XSH-RR output permutation.
`default_nettype none
module pcg_lcg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pcg_pkg::StateW-1:0] state_i,
  input  logic [pcg_pkg::StateW-1:0] inc_i,
  output pcg_pkg::lcg_res_t        res_o
);
  import pcg_pkg::*;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhLoLo  = 3'd1;
  localparam logic [2:0] PhLoHi  = 3'd2;
  localparam logic [2:0] PhHiLo  = 3'd3;
  localparam logic [2:0] PhAcc   = 3'd4;
  localparam logic [2:0] PhFinal = 3'd5;

  logic [2:0]          ph_q, ph_d;
  logic                done_q, done_d;
  logic [StateW-1:0]   old_q, acc_q, next_q;
  logic [2*WordW-1:0]  prod_q;
  logic [WordW-1:0]    mul_a, mul_b;
  logic [WordW-1:0]    mixed;
  logic [2*WordW-1:0]  mixed2;
  logic [4:0]          rot;

  always_comb begin
    mul_a = old_q[WordW-1:0];
    mul_b = LcgMult[WordW-1:0];
    case (ph_q)
      PhLoHi: begin
        mul_b = LcgMult[StateW-1:WordW];
      end
      PhHiLo: begin
        mul_a = old_q[StateW-1:WordW];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ph_d   = ph_q;
    done_d = 1'b0;
    case (ph_q)
      PhIdle:  if (start_i) ph_d = PhLoLo;
      PhLoLo:  ph_d = PhLoHi;
      PhLoHi:  ph_d = PhHiLo;
      PhHiLo:  ph_d = PhAcc;
      PhAcc:   ph_d = PhFinal;
      PhFinal: begin
        ph_d   = PhIdle;
        done_d = 1'b1;
      end
      default: ph_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhIdle;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  // Partial products: only the low half of each cross term reaches the result
  always_ff @(posedge clk_i) begin
    if (ph_q == PhIdle && start_i) old_q <= state_i;
    prod_q <= mul_a * mul_b;
    case (ph_q)
      PhLoHi: acc_q <= prod_q;
      PhHiLo, PhAcc: acc_q <= acc_q + {prod_q[WordW-1:0], {WordW{1'b0}}};
      PhFinal: next_q <= acc_q + inc_i;
      default: begin
      end
    endcase
  end

  // Xorshift high, then rotate right by the top five bits of the old state
  assign mixed  = old_q[58:27] ^ {13'd0, old_q[63:45]};
  assign rot    = old_q[63:59];
  assign mixed2 = {mixed, mixed} >> rot;

  assign res_o.done       = done_q;
  assign res_o.next_state = next_q;
  assign res_o.draw       = mixed2[WordW-1:0];

endmodule
`default_nettype wire

[rtl/pcg_div.sv]
// Restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module pcg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pcg_pkg::WordW-1:0] dividend_i,
  input  logic [pcg_pkg::WordW-1:0] divisor_i,
  output pcg_pkg::div_res_t         res_o
);
  import pcg_pkg::*;

  logic             busy_q, done_q;
  logic [4:0]       cnt_q;
  logic [WordW-1:0] dvd_q, rem_q;
  logic [WordW:0]   trial, diff;

  assign trial = {rem_q, dvd_q[WordW-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[WordW-2:0], 1'b0};
      rem_q <= diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

endmodule
`default_nettype wire

[rtl/pcg32_random_generator_core.sv]
// PCG32 XSH-RR generator core: request sequencer, state and result register.
//
// One request at a time: the block raises in_stall_o from the cycle after a
// request is taken until its result has been moved into the output register,
// which then waits on out_stall_i while the next request may already enter.
// The 64-bit LCG step runs on one shared 32x32 multiplier (three partial
// products, two accumulations, the increment add); a reseed steps twice.
// Remainders come from a one-bit-per-cycle restoring unit. A bounded draw
// first works out the rejection threshold (2^32 - bound) mod bound, then
// draws and retries while the draw is below it, then reduces the accepted
// draw modulo bound. A bound of zero and the unused operation code go
// straight to the result and leave the state alone.
// Configuration writes land at once; write them only while the block is idle.
`default_nettype none
module pcg32_random_generator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pcg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pcg_pkg::StateW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pcg_pkg::OpW-1:0]     op_i,
  input  logic [pcg_pkg::WordW-1:0]   bound_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pcg_pkg::WordW-1:0]   value_o,
  output logic                        bad_bound_o
);
  import pcg_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRs1  = 3'd1;
  localparam logic [2:0] StRs2  = 3'd2;
  localparam logic [2:0] StThr  = 3'd3;
  localparam logic [2:0] StDraw = 3'd4;
  localparam logic [2:0] StMod  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]         fsm_q, fsm_d;
  logic [StateW-1:0]  seed_q, lcg_state_q, lcg_state_d, inc_q, inc_d;
  logic [StreamW-1:0] stream_q;
  logic [OpW-1:0]     op_q, op_d;
  logic [WordW-1:0]   bound_q, bound_d, thr_q, thr_d, div_a_q, div_a_d;
  logic [WordW-1:0]   res_val_q, res_val_d, out_val_q;
  logic               res_bad_q, res_bad_d, out_bad_q;
  logic               go_q, go_d, div_go_q, div_go_d;
  logic               out_valid_q, out_free, in_acc;
  lcg_res_t           lcg_res;
  div_res_t           div_res;

  pcg_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .state_i (lcg_state_q),
    .inc_i   (inc_q),
    .res_o   (lcg_res)
  );

  pcg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_a_q),
    .divisor_i  (bound_q),
    .res_o      (div_res)
  );

  assign in_stall_o = (fsm_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    fsm_d       = fsm_q;
    lcg_state_d = lcg_state_q;
    inc_d       = inc_q;
    op_d        = op_q;
    bound_d     = bound_q;
    thr_d       = thr_q;
    div_a_d     = div_a_q;
    res_val_d   = res_val_q;
    res_bad_d   = res_bad_q;
    go_d        = 1'b0;
    div_go_d    = 1'b0;
    case (fsm_q)
      StIdle: begin
        if (in_acc) begin
          op_d      = op_i;
          bound_d   = bound_i;
          res_val_d = '0;
          res_bad_d = 1'b0;
          case (op_i)
            OpReseed: begin
              // Clear the state, load the odd increment, then step
              lcg_state_d = '0;
              inc_d       = {stream_q, 1'b1};
              go_d        = 1'b1;
              fsm_d       = StRs1;
            end
            OpRaw: begin
              go_d  = 1'b1;
              fsm_d = StDraw;
            end
            OpBounded: begin
              if (bound_i == '0) begin
                res_bad_d = 1'b1;
                fsm_d     = StDone;
              end else begin
                div_a_d  = '0 - bound_i;
                div_go_d = 1'b1;
                fsm_d    = StThr;
              end
            end
            default: fsm_d = StDone;
          endcase
        end
      end
      StRs1: begin
        if (lcg_res.done) begin
          lcg_state_d = lcg_res.next_state + seed_q;
          go_d        = 1'b1;
          fsm_d       = StRs2;
        end
      end
      StRs2: begin
        if (lcg_res.done) begin
          lcg_state_d = lcg_res.next_state;
          fsm_d       = StDone;
        end
      end
      StThr: begin
        if (div_res.done) begin
          thr_d = div_res.rem;
          go_d  = 1'b1;
          fsm_d = StDraw;
        end
      end
      StDraw: begin
        if (lcg_res.done) begin
          lcg_state_d = lcg_res.next_state;
          if (op_q == OpRaw) begin
            res_val_d = lcg_res.draw;
            fsm_d     = StDone;
          end else if (lcg_res.draw < thr_q) begin
            // Reject the biased low draw and draw again
            go_d = 1'b1;
          end else begin
            div_a_d  = lcg_res.draw;
            div_go_d = 1'b1;
            fsm_d    = StMod;
          end
        end
      end
      StMod: begin
        if (div_res.done) begin
          res_val_d = div_res.rem;
          fsm_d     = StDone;
        end
      end
      StDone: begin
        // Hold until the output register can take the result
        if (out_free) fsm_d = StIdle;
      end
      default: fsm_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= StIdle;
      seed_q      <= SeedReset;
      stream_q    <= StreamReset;
      lcg_state_q <= '0;
      inc_q       <= {{(StateW-1){1'b0}}, 1'b1};
      go_q        <= 1'b0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      lcg_state_q <= lcg_state_d;
      inc_q       <= inc_d;
      go_q        <= go_d;
      div_go_q    <= div_go_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSeed:   seed_q   <= cfg_wdata_i;
          CfgStream: stream_q <= cfg_wdata_i[StreamW-1:0];
          default: begin
          end
        endcase
      end
      if (fsm_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    bound_q   <= bound_d;
    thr_q     <= thr_d;
    div_a_q   <= div_a_d;
    res_val_q <= res_val_d;
    res_bad_q <= res_bad_d;
    if (fsm_q == StDone && out_free) begin
      out_val_q <= res_val_q;
      out_bad_q <= res_bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign bad_bound_o = out_bad_q;

endmodule
`default_nettype wire

[rtl/pcg_checker.sv]
// Port-level checks of the PCG32 core, bound to the top level.
`default_nettype none
module pcg_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_o,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic [pcg_pkg::WordW-1:0]   value_o,
  input  logic                        bad_bound_o
);

  // A taken request keeps the block busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken but block not busy");

  // A bad bound always comes with a zero value
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_bound_o |-> value_o == '0)
    else $error("bad bound with non-zero value");

  // A new result only appears after the block has been busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without preceding work");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o)
      && $stable(bad_bound_o))
    else $error("stalled result changed");

endmodule

bind pcg32_random_generator_core pcg_checker u_pcg_checker (.*);
`default_nettype wire
